// File: hdl/assert_macros.svh
// assertion macros used by the deframer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lprd_pkg.sv
// shared types and constants of the length-prefixed request deframer
package lprd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] MAX_MSG_RESET  = 16'd4096;
  localparam logic [15:0] MAX_ARGS_RESET = 16'd1024;
  localparam logic [31:0] MIN_BODY       = 32'd4;
  localparam logic [15:0] SIZE_HDR_BYTES = 16'd4;

  localparam logic [1:0] K_BYTE      = 2'd0;
  localparam logic [1:0] K_EMPTY_ARG = 2'd1;
  localparam logic [1:0] K_EMPTY_MSG = 2'd2;
  localparam logic [1:0] K_ERROR     = 2'd3;

  localparam logic REG_MAX_MSG  = 1'b0;
  localparam logic REG_MAX_ARGS = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  arg_byte;
    logic [15:0] arg_index;
    logic        last_of_arg;
    logic        last_of_message;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic dead;
  } parse_status_t;

endpackage

// File: hdl/lprd_parser.sv
// front end: framing state machine, one byte per accepted request
module lprd_parser import lprd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    stream_byte,
  input  logic [15:0]   max_message_bytes,
  input  logic [15:0]   max_arguments,
  output logic          res_valid,
  output result_t       res,
  output parse_status_t status
);

  localparam logic [2:0] PH_LEN   = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_SIZE  = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_DEAD  = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  hbs_r, hbs_nxt;
  logic [15:0] mbl_r, mbl_nxt;
  logic [15:0] al_r, al_nxt;
  logic [15:0] abl_r, abl_nxt;
  logic [15:0] ca_r, ca_nxt;

  logic        hdr_done;
  logic [31:0] hdr_val;
  logic [15:0] mbl_hdr;
  logic [15:0] mbl_dec;
  logic [15:0] abl_dec;
  logic [15:0] al_dec;

  assign hdr_done = (hbs_r == 2'd3);
  assign hdr_val  = {stream_byte, shift_r[31:8]};
  assign mbl_hdr  = mbl_r - SIZE_HDR_BYTES;
  assign mbl_dec  = mbl_r - 16'd1;
  assign abl_dec  = abl_r - 16'd1;
  assign al_dec   = al_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    hbs_nxt   = hbs_r;
    mbl_nxt   = mbl_r;
    al_nxt    = al_r;
    abl_nxt   = abl_r;
    ca_nxt    = ca_r;
    res_valid = 1'b0;
    res       = '0;
    if (accept) begin
      case (phase_r)
        PH_LEN: begin
          shift_nxt = hdr_val;
          hbs_nxt   = hbs_r + 2'd1;
          if (hdr_done) begin
            if (hdr_val > {16'd0, max_message_bytes} || hdr_val < MIN_BODY) begin
              phase_nxt = PH_DEAD;
              res_valid = 1'b1;
              res.kind  = K_ERROR;
            end else begin
              mbl_nxt   = hdr_val[15:0];
              phase_nxt = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          shift_nxt = hdr_val;
          hbs_nxt   = hbs_r + 2'd1;
          if (hdr_done) begin
            mbl_nxt = mbl_hdr;
            if (hdr_val > {16'd0, max_arguments}) begin
              phase_nxt = PH_DEAD;
              res_valid = 1'b1;
              res.kind  = K_ERROR;
            end else begin
              al_nxt = hdr_val[15:0];
              ca_nxt = '0;
              if (hdr_val[15:0] == 16'd0 && mbl_hdr == 16'd0) begin
                phase_nxt           = PH_LEN;
                res_valid           = 1'b1;
                res.kind            = K_EMPTY_MSG;
                res.last_of_message = 1'b1;
              end else begin
                // an empty count with body left errors on the next byte
                phase_nxt = PH_SIZE;
              end
            end
          end
        end
        PH_SIZE: begin
          if (hbs_r == 2'd0 && (al_r == 16'd0 || mbl_r < SIZE_HDR_BYTES)) begin
            phase_nxt = PH_DEAD;
            res_valid = 1'b1;
            res.kind  = K_ERROR;
          end else begin
            shift_nxt = hdr_val;
            hbs_nxt   = hbs_r + 2'd1;
            if (hdr_done) begin
              mbl_nxt = mbl_hdr;
              if (hdr_val > {16'd0, mbl_hdr}) begin
                phase_nxt = PH_DEAD;
                res_valid = 1'b1;
                res.kind  = K_ERROR;
              end else begin
                abl_nxt = hdr_val[15:0];
                if (hdr_val[15:0] == 16'd0) begin
                  al_nxt              = al_dec;
                  ca_nxt              = ca_r + 16'd1;
                  res_valid           = 1'b1;
                  res.kind            = K_EMPTY_ARG;
                  res.arg_index       = ca_r;
                  res.last_of_arg     = 1'b1;
                  res.last_of_message = (al_dec == 16'd0 && mbl_hdr == 16'd0);
                  phase_nxt = res.last_of_message ? PH_LEN : PH_SIZE;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          if (abl_r == 16'd0 || mbl_r == 16'd0) begin
            phase_nxt = PH_DEAD;
            res.kind  = K_ERROR;
          end else begin
            abl_nxt       = abl_dec;
            mbl_nxt       = mbl_dec;
            res.kind      = K_BYTE;
            res.arg_byte  = stream_byte;
            res.arg_index = ca_r;
            if (abl_dec == 16'd0) begin
              al_nxt              = al_dec;
              ca_nxt              = ca_r + 16'd1;
              res.last_of_arg     = 1'b1;
              res.last_of_message = (al_dec == 16'd0 && mbl_dec == 16'd0);
              phase_nxt = res.last_of_message ? PH_LEN : PH_SIZE;
            end
          end
        end
        default: begin
          // dead after an error: bytes are dropped
          phase_nxt = PH_DEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      hbs_r   <= '0;
      mbl_r   <= '0;
      al_r    <= '0;
      abl_r   <= '0;
      ca_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      hbs_r   <= hbs_nxt;
      mbl_r   <= mbl_nxt;
      al_r    <= al_nxt;
      abl_r   <= abl_nxt;
      ca_r    <= ca_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign status.dead = (phase_r == PH_DEAD);

endmodule

// File: hdl/lprd_queue.sv
// short result queue between the parser and the output stage
module lprd_queue import lprd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  result_t   push_data,
  input  logic      pop,
  output result_t   head,
  output q_status_t status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR   = AW'(DEPTH - 1);

  result_t       mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == FULL_COUNT);

endmodule

// File: hdl/lprd_back.sv
// back end: output register that drains the queue toward the result channel
module lprd_back import lprd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  input  result_t   head,
  input  logic      out_stall,
  output logic      pop,
  output logic      out_valid,
  output result_t   out_res
);

  logic    valid_r;
  result_t res_r;

  // load when the register is free or its request leaves this cycle
  assign pop = !q_status.empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: hdl/length_prefixed_request_deframer.sv
// top level of the length-prefixed request deframer
//
//   channel   handshake                   payload
//   in        in_valid / in_stall         in_stream_byte
//   out       out_valid / out_stall       out_kind, out_arg_byte, out_arg_index,
//                                         out_last_of_arg, out_last_of_message
//   cfg       psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one byte per cycle while in_stall is low: the parser updates its counters in the cycle a byte is taken
// a result passes through the queue, then the output register, before it reaches the output
// in_stall rises only while the QUEUE_DEPTH-entry queue is full
// synchronous active-low reset; limits return to 4096 bytes and 1024 arguments
// after a framing error the parser drops every byte until reset
`include "assert_macros.svh"

module length_prefixed_request_deframer import lprd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_arg_byte,
  output logic [15:0] out_arg_index,
  output logic        out_last_of_arg,
  output logic        out_last_of_message,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   max_msg_r;
  logic [15:0]   max_args_r;
  logic          cfg_wr;
  logic          accept;
  logic          res_valid;
  result_t       res;
  parse_status_t p_status;
  q_status_t     q_status;
  result_t       head;
  logic          pop;
  result_t       out_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r  <= MAX_MSG_RESET;
      max_args_r <= MAX_ARGS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_MSG:  max_msg_r  <= pwdata[15:0];
        REG_MAX_ARGS: max_args_r <= pwdata[15:0];
        default:      max_msg_r  <= max_msg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_MSG:  prdata = {16'd0, max_msg_r};
      REG_MAX_ARGS: prdata = {16'd0, max_args_r};
      default:      prdata = '0;
    endcase
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  lprd_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .stream_byte       (in_stream_byte),
    .max_message_bytes (max_msg_r),
    .max_arguments     (max_args_r),
    .res_valid         (res_valid),
    .res               (res),
    .status            (p_status)
  );

  lprd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  lprd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head      (head),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind            = out_res.kind;
  assign out_arg_byte        = out_res.arg_byte;
  assign out_arg_index       = out_res.arg_index;
  assign out_last_of_arg     = out_res.last_of_arg;
  assign out_last_of_message = out_res.last_of_message;

  `ASSERT_SAME(a_dead_silent, p_status.dead, !res_valid, "request produced after framing error")
  `ASSERT_NEXT(a_error_kills, res_valid && res.kind == K_ERROR, p_status.dead,
               "parser still live after error")
  `ASSERT_NEXT(a_back_fills, !q_status.empty && !out_valid, out_valid,
               "output register not loaded from queue")

endmodule
